### design/min_tracking_stack_macros.svh
// ----------------------------------------------------------------------------
// min tracking stack assertion macros
// concurrent check helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared constants and types of the min tracking stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

endpackage

### design/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// signed value stack with a running minimum kept on a second stack
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken when start is high and busy is low; op selects
//   push (value is stored) or pop (value is ignored).
//   every command gives exactly one result beat, marked by done for one
//   cycle, carrying top_value, min_value, depth_now, is_empty and status.
//   done is high in the cycle right after the accepting edge; busy is high
//   in the done cycle, so no new command is taken while a result is out.
//   the response state is there for the registered read of the value and
//   minimum rams: a pop needs the entry below the old top, which the ram
//   returns registered after the address is presented. the current tops
//   sit in registers.
//   push on full and pop on empty change nothing and report a status code.
//   reset clears both counts and the top registers; ram contents are not
//   cleared and need no clearing pass.
//   the receiver cannot stall: a result must be taken in its done cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_macros.svh"

module min_tracking_stack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [mts_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic signed [mts_pkg::DATA_W-1:0]   top_value,
    output logic signed [mts_pkg::DATA_W-1:0]   min_value,
    output logic        [mts_pkg::CNT_W-1:0]    depth_now,
    output logic                                is_empty,
    output logic        [1:0]                   status
);

    mts_pkg::state_t                      state_reg, state_next;
    logic        [mts_pkg::CNT_W-1:0]     count_reg, count_next;
    logic        [mts_pkg::CNT_W-1:0]     min_count_reg, min_count_next;
    logic signed [mts_pkg::DATA_W-1:0]    top_reg, top_next;
    logic signed [mts_pkg::DATA_W-1:0]    min_top_reg, min_top_next;
    logic                                 sel_top_reg, sel_top_next;
    logic                                 sel_min_reg, sel_min_next;
    mts_pkg::status_t                     status_reg, status_next;

    logic                                 accept;
    logic        [mts_pkg::CNT_W-1:0]     count_m2;
    logic        [mts_pkg::CNT_W-1:0]     min_count_m2;
    logic                                 val_we, val_re, min_we, min_re;
    logic        [mts_pkg::DATA_W-1:0]    val_rd_data, min_rd_data;
    logic signed [mts_pkg::DATA_W-1:0]    top_c, min_c;

    assign accept       = start && !busy;
    assign count_m2     = count_reg - mts_pkg::CNT_W'(2);
    assign min_count_m2 = min_count_reg - mts_pkg::CNT_W'(2);

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_val_ram (
        .clk     (clk),
        .we      (val_we),
        .wr_addr (count_reg[mts_pkg::ADDR_W-1:0]),
        .wr_data (value),
        .re      (val_re),
        .rd_addr (count_m2[mts_pkg::ADDR_W-1:0]),
        .rd_data (val_rd_data)
    );

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_min_ram (
        .clk     (clk),
        .we      (min_we),
        .wr_addr (min_count_reg[mts_pkg::ADDR_W-1:0]),
        .wr_data (value),
        .re      (min_re),
        .rd_addr (min_count_m2[mts_pkg::ADDR_W-1:0]),
        .rd_data (min_rd_data)
    );

    // next state
    always_comb
    begin
        case (state_reg)
            mts_pkg::S_IDLE: state_next = accept ? mts_pkg::S_RESP : mts_pkg::S_IDLE;
            mts_pkg::S_RESP: state_next = mts_pkg::S_IDLE;
            default:         state_next = mts_pkg::S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                busy = 1'b0;
                done = 1'b0;
            end
            mts_pkg::S_RESP:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
                done = 1'b0;
            end
        endcase
    end

    // tops after a pop that leaves an entry below come from the ram read
    assign top_c = sel_top_reg ? $signed(val_rd_data) : top_reg;
    assign min_c = sel_min_reg ? $signed(min_rd_data) : min_top_reg;

    always_comb
    begin
        count_next     = count_reg;
        min_count_next = min_count_reg;
        top_next       = top_reg;
        min_top_next   = min_top_reg;
        sel_top_next   = sel_top_reg;
        sel_min_next   = sel_min_reg;
        status_next    = status_reg;
        val_we         = 1'b0;
        val_re         = 1'b0;
        min_we         = 1'b0;
        min_re         = 1'b0;

        if (state_reg == mts_pkg::S_IDLE && accept)
        begin
            sel_top_next = 1'b0;
            sel_min_next = 1'b0;
            status_next  = mts_pkg::ST_OK;
            if (op == mts_pkg::OP_PUSH)
            begin
                if (count_reg == mts_pkg::FULL_COUNT)
                begin
                    status_next = mts_pkg::ST_FULL;
                end
                else
                begin
                    val_we     = 1'b1;
                    count_next = count_reg + mts_pkg::CNT_W'(1);
                    top_next   = value;
                    if (min_count_reg != mts_pkg::FULL_COUNT &&
                        (min_count_reg == '0 || value <= min_top_reg))
                    begin
                        min_we         = 1'b1;
                        min_count_next = min_count_reg + mts_pkg::CNT_W'(1);
                        min_top_next   = value;
                    end
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = mts_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - mts_pkg::CNT_W'(1);
                    if (count_reg >= mts_pkg::CNT_W'(2))
                    begin
                        val_re       = 1'b1;
                        sel_top_next = 1'b1;
                    end
                    else
                    begin
                        top_next = '0;
                    end
                    if (min_count_reg != '0 && min_top_reg == top_reg)
                    begin
                        min_count_next = min_count_reg - mts_pkg::CNT_W'(1);
                        if (min_count_reg >= mts_pkg::CNT_W'(2))
                        begin
                            min_re       = 1'b1;
                            sel_min_next = 1'b1;
                        end
                        else
                        begin
                            min_top_next = '0;
                        end
                    end
                end
            end
        end
        else if (state_reg == mts_pkg::S_RESP)
        begin
            top_next     = top_c;
            min_top_next = min_c;
            sel_top_next = 1'b0;
            sel_min_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mts_pkg::S_IDLE;
            count_reg     <= '0;
            min_count_reg <= '0;
            top_reg       <= '0;
            min_top_reg   <= '0;
            sel_top_reg   <= 1'b0;
            sel_min_reg   <= 1'b0;
            status_reg    <= mts_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
            top_reg       <= top_next;
            min_top_reg   <= min_top_next;
            sel_top_reg   <= sel_top_next;
            sel_min_reg   <= sel_min_next;
            status_reg    <= status_next;
        end
    end

    assign top_value = top_c;
    assign min_value = min_c;
    assign depth_now = count_reg;
    assign is_empty  = (count_reg == '0);
    assign status    = status_reg;

    `MTS_ASSERT_NOW(a_min_le_count, clk, rst_n, 1'b1, min_count_reg <= count_reg,
        "min stack deeper than value stack")
    `MTS_ASSERT_NEXT(a_accept_done, clk, rst_n, accept, done,
        "no result beat after command")
    `MTS_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= mts_pkg::FULL_COUNT,
        "count beyond depth")
    `MTS_ASSERT_NOW(a_full_status, clk, rst_n, done && status_reg == mts_pkg::ST_FULL,
        count_reg == mts_pkg::FULL_COUNT, "full status while not full")
    `MTS_ASSERT_NOW(a_empty_min, clk, rst_n, done && is_empty,
        min_count_reg == '0 && top_value == '0 && min_value == '0,
        "empty stack with live min")

endmodule

### bench/min_tracking_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Drives push and pop commands through the start/busy handshake with random
// gaps, and keeps a shadow copy of the value stack and the minimum stack.
// Each done beat is compared field by field with the oldest predicted view.
// A short directed run covers empty pops, extreme values and ties. Random
// phases then fill the stack to full, drain it past empty and walk between.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

    localparam int QUIET_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASE_COUNT     = 6;

    typedef struct {
        logic signed [mts_pkg::DATA_W-1:0] top;
        logic signed [mts_pkg::DATA_W-1:0] low;
        logic        [mts_pkg::CNT_W-1:0]  depth;
        logic                              empty;
        mts_pkg::status_t                  status;
    } stack_view_t;

    class min_stack_predictor;
        logic signed [mts_pkg::DATA_W-1:0] value_mem [mts_pkg::STACK_DEPTH];
        logic signed [mts_pkg::DATA_W-1:0] min_mem   [mts_pkg::STACK_DEPTH];
        int                                value_depth;
        int                                min_depth;
        int                                mismatches;
        stack_view_t                       pending_views [$];

        function new();
            value_depth = 0;
            min_depth   = 0;
            mismatches  = 0;
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task note_command(input logic cmd,
                          input logic signed [mts_pkg::DATA_W-1:0] operand);
            stack_view_t v;
            v.status = mts_pkg::ST_OK;
            if (cmd == mts_pkg::OP_PUSH)
            begin
                if (value_depth >= mts_pkg::STACK_DEPTH)
                begin
                    v.status = mts_pkg::ST_FULL;
                end
                else
                begin
                    value_mem[value_depth] = operand;
                    value_depth++;
                    if (min_depth < mts_pkg::STACK_DEPTH &&
                        (min_depth == 0 || operand <= min_mem[min_depth-1]))
                    begin
                        min_mem[min_depth] = operand;
                        min_depth++;
                    end
                end
            end
            else
            begin
                if (value_depth == 0)
                begin
                    v.status = mts_pkg::ST_EMPTY;
                end
                else
                begin
                    if (min_depth > 0 && min_mem[min_depth-1] == value_mem[value_depth-1])
                        min_depth--;
                    value_depth--;
                end
            end
            v.top   = (value_depth > 0) ? value_mem[value_depth-1] : '0;
            v.low   = (min_depth > 0) ? min_mem[min_depth-1] : '0;
            v.depth = mts_pkg::CNT_W'(value_depth);
            v.empty = (value_depth == 0);
            pending_views = {pending_views, v};
        endtask

        task check_result(input logic signed [mts_pkg::DATA_W-1:0] top,
                          input logic signed [mts_pkg::DATA_W-1:0] low,
                          input logic [mts_pkg::CNT_W-1:0] depth,
                          input logic empty,
                          input logic [1:0] st);
            stack_view_t want;
            if (pending_views.size() == 0)
            begin
                report_mismatch("result beat with no command pending");
                return;
            end
            want = pending_views.pop_front();
            if (top !== want.top)
                report_mismatch($sformatf("top_value expected %0d got %0d", want.top, top));
            if (low !== want.low)
                report_mismatch($sformatf("min_value expected %0d got %0d", want.low, low));
            if (depth !== want.depth)
                report_mismatch($sformatf("depth_now expected %0d got %0d", want.depth, depth));
            if (empty !== want.empty)
                report_mismatch($sformatf("is_empty expected %0b got %0b", want.empty, empty));
            if (st !== want.status)
                report_mismatch($sformatf("status expected %0d got %0d", want.status, st));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              op    = mts_pkg::OP_PUSH;
    logic signed [mts_pkg::DATA_W-1:0] value = '0;
    logic                              busy;
    logic                              done;
    logic signed [mts_pkg::DATA_W-1:0] top_value;
    logic signed [mts_pkg::DATA_W-1:0] min_value;
    logic        [mts_pkg::CNT_W-1:0]  depth_now;
    logic                              is_empty;
    logic        [1:0]                 status;

    min_stack_predictor expected_stack = new();
    int                 quiet_cycles = 0;
    bit                 bursty = 1'b0;

    min_tracking_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .done      (done),
        .top_value (top_value),
        .min_value (min_value),
        .depth_now (depth_now),
        .is_empty  (is_empty),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                expected_stack.check_result(top_value, min_value, depth_now, is_empty, status);
            if (start && !busy)
                expected_stack.note_command(op, value);
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (bursty || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $signed($urandom_range(0, 8)) - 4;
        if (r < 40)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh00000000;
                default: return 32'shffffffff;
            endcase
        end
        return $urandom;
    endfunction

    task automatic issue_and_wait(input logic cmd,
                                  input logic signed [mts_pkg::DATA_W-1:0] operand);
        int gap;
        op    <= cmd;
        value <= operand;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            op    <= 1'($urandom);
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int   push_share [PHASE_COUNT];
        logic cmd;

        push_share = '{90, 50, 10, 95, 40, 70};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pop, ties on the minimum, signed extremes
        issue_and_wait(mts_pkg::OP_POP,  32'sd9);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sd5);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sd5);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sd7);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sh7fffffff);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sh80000000);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sh80000000);
        issue_and_wait(mts_pkg::OP_PUSH, 32'shffffffff);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sh00000000);
        issue_and_wait(mts_pkg::OP_POP,  32'shffffffff);
        issue_and_wait(mts_pkg::OP_POP,  32'shffffffff);
        issue_and_wait(mts_pkg::OP_POP,  32'shffffffff);
        issue_and_wait(mts_pkg::OP_POP,  32'shffffffff);
        issue_and_wait(mts_pkg::OP_POP,  32'shffffffff);
        issue_and_wait(mts_pkg::OP_POP,  32'sh55555555);
        issue_and_wait(mts_pkg::OP_PUSH, 32'shffffffff);
        issue_and_wait(mts_pkg::OP_PUSH, 32'sd1);
        issue_and_wait(mts_pkg::OP_PUSH, -32'sd2);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);
        issue_and_wait(mts_pkg::OP_POP,  32'sd0);

        // fill past full, random walk, drain past empty
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            bursty = (phase == 2 || phase == 4);
            repeat (ITEMS_PER_PHASE)
            begin
                cmd = ($urandom_range(0, 99) < push_share[phase]) ?
                      mts_pkg::OP_PUSH : mts_pkg::OP_POP;
                issue_and_wait(cmd, pick_value());
            end
        end

        start <= 1'b0;
        while (expected_stack.pending_views.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (expected_stack.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
